// ===== sv/bthin_pkg.sv =====
// Shared types, constants and the two-subiteration deletion test for the thinning block.
// No dependencies; every other file imports this package.
package bthin_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MAX_PASSES   = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] PASS_SAT = 8'hff;

  // sweep phases: center and neighbor reads, then capture of the last one, then mark
  localparam logic [3:0] PH_FIRST   = 4'd0;
  localparam logic [3:0] PH_LAST_RD = 4'd8;
  localparam logic [3:0] PH_MARK    = 4'd10;

  typedef struct packed {
    logic cmd;
    logic pixel_in;
  } in_t;

  typedef struct packed {
    logic       pixel_out;
    logic       last_pixel;
    logic [7:0] passes_run;
  } out_t;

  typedef struct packed {
    logic       busy;
    logic       scan_rd;
    logic       mark_we;
    logic       apply_rd;
    logic       sweep_clr;
    logic       sweep_adv;
    logic       second;
    logic       any_clr;
    logic       done;
    logic [3:0] phase;
    logic [7:0] passes;
  } ctl_t;

  typedef struct packed {
    logic       sweep_last;
    logic       frame_loaded;
    logic       any_mark;
    logic [7:0] max_passes;
  } sts_t;

  // x[0] is the center, x[1..8] the neighbors counterclockwise from east
  function automatic logic deletable(input logic [8:0] x, input logic second);
    logic [2:0] cn;
    logic [2:0] n1;
    logic [2:0] n2;
    logic [2:0] mn;
    logic       g3;
    cn = 3'((~x[1]) & (x[2] | x[3])) + 3'((~x[3]) & (x[4] | x[5]))
       + 3'((~x[5]) & (x[6] | x[7])) + 3'((~x[7]) & (x[8] | x[1]));
    n1 = 3'(x[1] | x[2]) + 3'(x[3] | x[4]) + 3'(x[5] | x[6]) + 3'(x[7] | x[8]);
    n2 = 3'(x[2] | x[3]) + 3'(x[4] | x[5]) + 3'(x[6] | x[7]) + 3'(x[8] | x[1]);
    mn = (n1 < n2) ? n1 : n2;
    if (!second) begin
      g3 = (x[2] | x[3] | ~x[8]) & x[1];
    end else begin
      g3 = (x[6] | x[7] | ~x[4]) & x[5];
    end
    return x[0] && (cn == 3'd1) && (mn >= 3'd2) && (mn <= 3'd3) && !g3;
  endfunction

endpackage

// ===== sv/bthin_ctrl.sv =====
// Thinning sequencer: sweep phases, subiterations and pass counting.
// Depends on bthin_pkg; drives the datapath through ctl_t.
module bthin_ctrl
  import bthin_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic       second_r, second_nxt;
  logic [7:0] pass_r, pass_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    second_nxt    = second_r;
    pass_nxt      = pass_r;
    ctl           = '0;
    ctl.busy      = (state_r != S_IDLE);
    ctl.phase     = phase_r;
    ctl.second    = second_r;
    ctl.passes    = pass_r;
    case (state_r)
      S_IDLE: begin
        if (sts.frame_loaded) begin
          state_nxt     = S_SCAN;
          phase_nxt     = PH_FIRST;
          pass_nxt      = 8'd1;
          second_nxt    = 1'b0;
          ctl.sweep_clr = 1'b1;
          ctl.any_clr   = 1'b1;
        end
      end
      S_SCAN: begin
        ctl.scan_rd = (phase_r <= PH_LAST_RD);
        if (phase_r == PH_MARK) begin
          ctl.mark_we = 1'b1;
          phase_nxt   = PH_FIRST;
          if (sts.sweep_last) begin
            ctl.sweep_clr = 1'b1;
            state_nxt     = S_APPLY;
          end else begin
            ctl.sweep_adv = 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 4'd1;
        end
      end
      S_APPLY: begin
        ctl.apply_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_FLUSH;
        end else begin
          ctl.sweep_adv = 1'b1;
        end
      end
      S_FLUSH: begin
        ctl.sweep_clr = 1'b1;
        if (!second_r) begin
          second_nxt = 1'b1;
          state_nxt  = S_SCAN;
        end else if (!sts.any_mark ||
                     (sts.max_passes != 8'd0 && pass_r == sts.max_passes)) begin
          ctl.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pass_nxt    = (pass_r == PASS_SAT) ? pass_r : pass_r + 8'd1;
          second_nxt  = 1'b0;
          ctl.any_clr = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_FIRST;
      second_r <= 1'b0;
      pass_r   <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
      pass_r   <= pass_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> phase_r <= PH_MARK)
    else $error("sweep phase out of range");
  a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> state_r == S_SCAN || state_r == S_IDLE)
    else $error("bad exit from flush");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> state_r == S_IDLE && !ctl.busy)
    else $error("done without returning idle");
`endif

endmodule

// ===== sv/bthin_dp.sv =====
// Datapath: configuration, pixel and mark stores, sweep counters, neighbor
// window and the handshakes of both channels. Depends on bthin_pkg.
module bthin_dp
  import bthin_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  ctl_t              ctl,
  output sts_t              sts
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);

  logic [CFG_DW-1:0] cfg_w_r, cfg_h_r;
  logic [7:0]        cfg_max_r;
  logic [WW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;
  logic [TW-1:0]     tot, tot_m1;

  logic [AW-1:0] load_pos_r, read_pos_r, lp_cur, rp_cur;
  logic [TW-1:0] lp_inc, rp_inc;
  logic          frame_ready_r;
  logic          in_acc, ld_acc, rd_acc;

  logic          pix_mem [DEPTH];
  logic          mark_mem [DEPTH];
  logic          rd_q, mk_q;
  logic          pix_we, pix_wd, rd_en;
  logic [AW-1:0] pix_wa, rd_addr;

  logic [AW-1:0] idx_r, nb_addr, ap_addr_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [WW-1:0] col_p1;
  logic [HW-1:0] row_p1;
  logic          inb, cap_v_r, cap_in_r, ap_v_r, any_r, mark;
  logic [3:0]    cap_ph_r;
  logic [8:0]    nb_r;

  logic          out_valid_r, out_last_r;
  logic [7:0]    out_passes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= CFG_DW'(256);
      cfg_h_r   <= CFG_DW'(256);
      cfg_max_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_w_r   <= cfg_data;
        CFG_FRAME_HEIGHT: cfg_h_r   <= cfg_data;
        CFG_MAX_PASSES:   cfg_max_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h_r);
    end
  end

  assign tot    = TW'(eff_w) * TW'(eff_h);
  assign tot_m1 = tot - TW'(1);

  // positions beyond a shrunken frame restart at zero
  assign lp_cur = (TW'(load_pos_r) >= tot) ? '0 : load_pos_r;
  assign rp_cur = (TW'(read_pos_r) >= tot) ? '0 : read_pos_r;
  assign lp_inc = TW'(lp_cur) + TW'(1);
  assign rp_inc = TW'(rp_cur) + TW'(1);

  assign in_ready = !ctl.busy && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign ld_acc   = in_acc && (in_data.cmd == CMD_LOAD);
  assign rd_acc   = in_acc && (in_data.cmd == CMD_READ) && frame_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r    <= '0;
      read_pos_r    <= '0;
      frame_ready_r <= 1'b0;
    end else begin
      if (ld_acc) begin
        load_pos_r    <= (lp_inc >= tot) ? '0 : AW'(lp_inc);
        read_pos_r    <= '0;
        frame_ready_r <= 1'b0;
      end else begin
        if (rd_acc) begin
          read_pos_r <= (rp_inc >= tot) ? '0 : AW'(rp_inc);
        end
        if (ctl.done) begin
          frame_ready_r <= 1'b1;
        end
      end
    end
  end

  // neighbor address and in-frame check for the current phase
  assign col_p1 = WW'(col_r) + WW'(1);
  assign row_p1 = HW'(row_r) + HW'(1);

  always_comb begin
    nb_addr = idx_r;
    inb     = 1'b1;
    case (ctl.phase)
      4'd1: begin nb_addr = idx_r + AW'(1);
        inb = (col_p1 < eff_w); end
      4'd2: begin nb_addr = idx_r - AW'(eff_w) + AW'(1);
        inb = (row_r != '0) && (col_p1 < eff_w); end
      4'd3: begin nb_addr = idx_r - AW'(eff_w);
        inb = (row_r != '0); end
      4'd4: begin nb_addr = idx_r - AW'(eff_w) - AW'(1);
        inb = (row_r != '0) && (col_r != '0); end
      4'd5: begin nb_addr = idx_r - AW'(1);
        inb = (col_r != '0); end
      4'd6: begin nb_addr = idx_r + AW'(eff_w) - AW'(1);
        inb = (row_p1 < eff_h) && (col_r != '0); end
      4'd7: begin nb_addr = idx_r + AW'(eff_w);
        inb = (row_p1 < eff_h); end
      4'd8: begin nb_addr = idx_r + AW'(eff_w) + AW'(1);
        inb = (row_p1 < eff_h) && (col_p1 < eff_w); end
      default: begin nb_addr = idx_r; inb = 1'b1; end
    endcase
  end

  assign pix_we  = ld_acc || (ap_v_r && mk_q);
  assign pix_wa  = ld_acc ? lp_cur : ap_addr_r;
  assign pix_wd  = ld_acc ? in_data.pixel_in : 1'b0;
  assign rd_en   = rd_acc || ctl.scan_rd;
  assign rd_addr = rd_acc ? rp_cur : nb_addr;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_wa] <= pix_wd;
    end
    if (rd_en) begin
      rd_q <= pix_mem[rd_addr];
    end
  end

  assign mark = deletable(nb_r, ctl.second);

  always_ff @(posedge clk) begin
    if (ctl.mark_we) begin
      mark_mem[idx_r] <= mark;
    end
    if (ctl.apply_rd) begin
      mk_q <= mark_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_v_r <= 1'b0;
      ap_v_r  <= 1'b0;
      any_r   <= 1'b0;
      idx_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      cap_v_r <= ctl.scan_rd;
      ap_v_r  <= ctl.apply_rd;
      if (ctl.any_clr) begin
        any_r <= 1'b0;
      end else if (ctl.mark_we && mark) begin
        any_r <= 1'b1;
      end
      if (ctl.sweep_clr) begin
        idx_r <= '0;
        col_r <= '0;
        row_r <= '0;
      end else if (ctl.sweep_adv) begin
        idx_r <= idx_r + AW'(1);
        if (col_p1 == eff_w) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  // read data lands in the cycle after its address; mask out-of-frame taps
  always_ff @(posedge clk) begin
    cap_ph_r  <= ctl.phase;
    cap_in_r  <= inb;
    ap_addr_r <= idx_r;
    if (cap_v_r) begin
      nb_r[cap_ph_r] <= rd_q & cap_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      out_last_r   <= (TW'(rp_cur) == tot_m1);
      out_passes_r <= ctl.passes;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.pixel_out  = rd_q;
  assign out_data.last_pixel = out_last_r;
  assign out_data.passes_run = out_passes_r;

  assign sts.sweep_last   = (TW'(idx_r) == tot_m1);
  assign sts.frame_loaded = ld_acc && (lp_inc >= tot);
  assign sts.any_mark     = any_r;
  assign sts.max_passes   = cfg_max_r;

endmodule

// ===== sv/binary_image_thinning.sv =====
// Binary image thinning, top level: two-subiteration thinning of a frame held on chip.
// Load transactions (cmd load) write pixels in raster order; the last pixel of
// the frame starts thinning. Read transactions (cmd read) return the thinned
// frame in raster order, one result each, with last_pixel on the final pixel
// and the pass count; reads before a frame is thinned give no result, and
// readout wraps to the first pixel after the last.
// Load and read transactions can follow one another without gaps while not
// thinning and out_ready is high; a read result appears in the output register
// in the cycle after acceptance. in_ready drops while thinning. Thinning time is
// set by the single read port of the pixel store: each pixel is visited in each
// subiteration in phases (nine reads, capture, mark), then a sweep applies the
// marks and a flush step follows; passes repeat until none deletes or the limit.
// Reset (synchronous, rst_n low) clears positions, the ready flag and restores
// width 256, height 256, unlimited passes; the pixel store is not cleared.
// When out_ready is low while a result is valid, the result holds and no new transaction is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect next cycle.
module binary_image_thinning
  import bthin_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  bthin_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  bthin_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
